FILE: src/step_dir_pulse_generator_defines.svh
// Assertion helpers shared by the RTL.
`ifndef STEP_DIR_PULSE_GENERATOR_DEFINES_SVH
`define STEP_DIR_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define SDPG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdpg assertion failed");

// Next-cycle implication.
`define SDPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdpg assertion failed");

`endif

FILE: src/sdpg_pkg.sv
package sdpg_pkg;

   localparam int unsigned AXES_DEFAULT         = 8;
   localparam int unsigned PERIOD_WIDTH_DEFAULT = 24;
   localparam int unsigned PERIOD_RESET         = 100000;
   localparam logic [6:0]  FRAC_WRAP            = 7'd100;

   typedef enum logic [2:0] {
      FUNC_TICK       = 3'd0,
      FUNC_MOVE       = 3'd1,
      FUNC_GOTO       = 3'd2,
      FUNC_SET_POS    = 3'd3,
      FUNC_SET_PERIOD = 3'd4
   } func_type;

   typedef struct packed {
      logic        pulse;
      logic        dir;
      logic [31:0] remaining;
      logic [31:0] position;
      logic [6:0]  frac;
   } axis_state_type;

endpackage

FILE: src/sdpg_req_if.sv
interface sdpg_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [2:0]  axis;
   logic [31:0] move_steps;
   logic [31:0] target_position;
   logic [31:0] new_position;
   logic [23:0] period_whole;
   logic [6:0]  period_hundredths;

   modport source (
      output valid, func, axis, move_steps, target_position, new_position,
             period_whole, period_hundredths,
      input  ready
   );
   modport sink (
      input  valid, func, axis, move_steps, target_position, new_position,
             period_whole, period_hundredths,
      output ready
   );
endinterface

FILE: src/sdpg_rsp_if.sv
interface sdpg_rsp_if;
   logic        valid;
   logic        ready;
   logic        step_level;
   logic        dir_level;
   logic [31:0] steps_left;
   logic [31:0] position;
   logic        busy_res;

   modport source (
      output valid, step_level, dir_level, steps_left, position, busy_res,
      input  ready
   );
   modport sink (
      input  valid, step_level, dir_level, steps_left, position, busy_res,
      output ready
   );
endinterface

FILE: src/step_dir_pulse_generator.sv
// Step/direction pulse generator, one set of counters per axis. Every transfer
// on req_bus names an axis and an operation (tick, relative move, goto, set
// position, set period) and yields exactly one transfer on rsp_bus with that
// axis's step and direction levels, remaining steps and position after the
// operation. One item is taken per clock; each request passes the input
// register, then the result register, with the per-axis state held in
// flip-flops so the next item sees it at once. The rate
// is set only by rsp_bus backpressure. Write csr_wr_data (direction inversion,
// one bit per axis) only while no items are in flight.
`include "step_dir_pulse_generator_defines.svh"

module step_dir_pulse_generator #(
   parameter int unsigned AXES         = sdpg_pkg::AXES_DEFAULT,
   parameter int unsigned PERIOD_WIDTH = sdpg_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data,
   sdpg_req_if.sink        req_bus,
   sdpg_rsp_if.source      rsp_bus
);

   localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_INIT = PERIOD_WIDTH'(sdpg_pkg::PERIOD_RESET);

   logic [7:0] mask_ff;

   // input register
   logic        s1_valid_ff;
   logic [2:0]  s1_func_ff;
   logic [2:0]  s1_axis_ff;
   logic [31:0] s1_move_ff;
   logic [31:0] s1_target_ff;
   logic [31:0] s1_newpos_ff;
   logic [23:0] s1_whole_ff;
   logic [6:0]  s1_hund_ff;

   // per-axis state
   logic                    pulse_ff      [AXES];
   logic                    dir_ff        [AXES];
   logic [31:0]             remaining_ff  [AXES];
   logic [31:0]             position_ff   [AXES];
   logic [PERIOD_WIDTH-1:0] period_int_ff [AXES];
   logic [6:0]              period_frac_ff[AXES];
   logic [PERIOD_WIDTH-1:0] tick_ff       [AXES];
   logic [6:0]              frac_ff       [AXES];

   // result register
   logic        rsp_valid_ff;
   logic        rsp_step_ff;
   logic        rsp_dir_ff;
   logic [31:0] rsp_steps_ff;
   logic [31:0] rsp_pos_ff;
   logic        rsp_busy_ff;

   logic                     advance;
   logic                     in_range;
   logic [AW-1:0]            idx;
   sdpg_pkg::axis_state_type cur;
   sdpg_pkg::axis_state_type nxt;
   logic [PERIOD_WIDTH-1:0]  cur_period_int;
   logic [6:0]               cur_period_frac;
   logic [PERIOD_WIDTH-1:0]  cur_tick;
   logic [PERIOD_WIDTH-1:0]  period_int_in;
   logic [6:0]               period_frac_in;
   logic [PERIOD_WIDTH-1:0]  tick_in;

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign in_range      = 32'(s1_axis_ff) < AXES;
   assign idx           = AW'(s1_axis_ff);

   always_comb begin
      if (in_range) begin
         cur.pulse       = pulse_ff[idx];
         cur.dir         = dir_ff[idx];
         cur.remaining   = remaining_ff[idx];
         cur.position    = position_ff[idx];
         cur.frac        = frac_ff[idx];
         cur_period_int  = period_int_ff[idx];
         cur_period_frac = period_frac_ff[idx];
         cur_tick        = tick_ff[idx];
      end else begin
         cur             = '0;
         cur_period_int  = '0;
         cur_period_frac = '0;
         cur_tick        = '0;
      end
   end

   sdpg_axis_update #(
      .PERIOD_WIDTH(PERIOD_WIDTH)
   ) u_update (
      .func              (s1_func_ff),
      .rev_bit           (mask_ff[s1_axis_ff]),
      .move_steps        (s1_move_ff),
      .target_position   (s1_target_ff),
      .new_position      (s1_newpos_ff),
      .period_whole      (s1_whole_ff),
      .period_hundredths (s1_hund_ff),
      .cur               (cur),
      .cur_period_int    (cur_period_int),
      .cur_period_frac   (cur_period_frac),
      .cur_tick          (cur_tick),
      .nxt               (nxt),
      .nxt_period_int    (period_int_in),
      .nxt_period_frac   (period_frac_in),
      .nxt_tick          (tick_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_func_ff   <= req_bus.func;
         s1_axis_ff   <= req_bus.axis;
         s1_move_ff   <= req_bus.move_steps;
         s1_target_ff <= req_bus.target_position;
         s1_newpos_ff <= req_bus.new_position;
         s1_whole_ff  <= req_bus.period_whole;
         s1_hund_ff   <= req_bus.period_hundredths;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            pulse_ff[i]       <= 1'b0;
            dir_ff[i]         <= 1'b0;
            remaining_ff[i]   <= '0;
            position_ff[i]    <= '0;
            period_int_ff[i]  <= PERIOD_INIT;
            period_frac_ff[i] <= '0;
            tick_ff[i]        <= '0;
            frac_ff[i]        <= '0;
         end
      end else if (advance && in_range) begin
         pulse_ff[idx]       <= nxt.pulse;
         dir_ff[idx]         <= nxt.dir;
         remaining_ff[idx]   <= nxt.remaining;
         position_ff[idx]    <= nxt.position;
         period_int_ff[idx]  <= period_int_in;
         period_frac_ff[idx] <= period_frac_in;
         tick_ff[idx]        <= tick_in;
         frac_ff[idx]        <= nxt.frac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // out-of-range axis reports all zero
   always_ff @(posedge clock) begin
      if (advance) begin
         if (in_range) begin
            rsp_step_ff  <= nxt.pulse;
            rsp_dir_ff   <= nxt.dir;
            rsp_steps_ff <= nxt.remaining;
            rsp_pos_ff   <= nxt.position;
            rsp_busy_ff  <= nxt.remaining != 32'd0;
         end else begin
            rsp_step_ff  <= 1'b0;
            rsp_dir_ff   <= 1'b0;
            rsp_steps_ff <= '0;
            rsp_pos_ff   <= '0;
            rsp_busy_ff  <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.step_level = rsp_step_ff;
   assign rsp_bus.dir_level  = rsp_dir_ff;
   assign rsp_bus.steps_left = rsp_steps_ff;
   assign rsp_bus.position   = rsp_pos_ff;
   assign rsp_bus.busy_res   = rsp_busy_ff;

   `SDPG_ASSERT_NEXT(a_req_loads_s1, clock, reset, req_bus.valid && req_bus.ready, s1_valid_ff)
   `SDPG_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !advance,
                     s1_valid_ff && $stable(s1_axis_ff) && $stable(s1_func_ff))
   `SDPG_ASSERT_NEXT(a_rsp_drains, clock, reset, rsp_valid_ff && rsp_bus.ready && !s1_valid_ff,
                     !rsp_valid_ff)
   `SDPG_ASSERT_NOW(a_busy_match, clock, reset, rsp_valid_ff,
                    rsp_busy_ff == (rsp_steps_ff != 32'd0))

endmodule

FILE: src/sdpg_axis_update.sv
module sdpg_axis_update #(
   parameter int unsigned PERIOD_WIDTH = sdpg_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic [2:0]                 func,
   input  logic                       rev_bit,
   input  logic [31:0]                move_steps,
   input  logic [31:0]                target_position,
   input  logic [31:0]                new_position,
   input  logic [23:0]                period_whole,
   input  logic [6:0]                 period_hundredths,
   input  sdpg_pkg::axis_state_type   cur,
   input  logic [PERIOD_WIDTH-1:0]    cur_period_int,
   input  logic [6:0]                 cur_period_frac,
   input  logic [PERIOD_WIDTH-1:0]    cur_tick,
   output sdpg_pkg::axis_state_type   nxt,
   output logic [PERIOD_WIDTH-1:0]    nxt_period_int,
   output logic [6:0]                 nxt_period_frac,
   output logic [PERIOD_WIDTH-1:0]    nxt_tick
);

   logic [32:0]             goto_diff;
   logic [31:0]             goto_steps;
   logic [31:0]             move_val;
   logic [PERIOD_WIDTH-1:0] tick_inc;
   logic [6:0]              frac_inc;

   assign goto_diff = {target_position[31], target_position}
                    - {cur.position[31], cur.position};

   always_comb begin
      if (goto_diff[32] != goto_diff[31]) begin
         goto_steps = goto_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         goto_steps = goto_diff[31:0];
      end
   end

   assign move_val = (func == sdpg_pkg::FUNC_GOTO) ? goto_steps : move_steps;
   assign tick_inc = cur_tick + PERIOD_WIDTH'(1);
   assign frac_inc = cur.frac + 7'd1;

   always_comb begin
      nxt             = cur;
      nxt_period_int  = cur_period_int;
      nxt_period_frac = cur_period_frac;
      nxt_tick        = cur_tick;
      case (func)
         sdpg_pkg::FUNC_TICK: begin
            nxt.pulse = 1'b0;
            if (cur.remaining != 32'd0) begin
               if (tick_inc < cur_period_int) begin
                  nxt_tick = tick_inc;
               end else begin
                  nxt_tick  = (cur.frac > cur_period_frac) ? PERIOD_WIDTH'(1)
                                                           : '0;
                  nxt.frac  = (frac_inc >= sdpg_pkg::FRAC_WRAP) ? 7'd0 : frac_inc;
                  nxt.pulse = 1'b1;
                  if (cur.remaining[31]) begin
                     nxt.remaining = cur.remaining + 32'd1;
                     nxt.position  = cur.position - 32'd1;
                  end else begin
                     nxt.remaining = cur.remaining - 32'd1;
                     nxt.position  = cur.position + 32'd1;
                  end
               end
            end
         end
         sdpg_pkg::FUNC_MOVE, sdpg_pkg::FUNC_GOTO: begin
            nxt.remaining = move_val;
            if (move_val != 32'd0) begin
               nxt.dir = ~move_val[31] ^ rev_bit;
            end
         end
         sdpg_pkg::FUNC_SET_POS: begin
            nxt.position = new_position;
         end
         sdpg_pkg::FUNC_SET_PERIOD: begin
            nxt_period_int  = PERIOD_WIDTH'(period_whole);
            nxt_period_frac = period_hundredths;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;

   localparam logic [2:0] FUNC_RSVD_5 = 3'd5;
   localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
   localparam logic [2:0] FUNC_RSVD_7 = 3'd7;
   localparam int     N_AXES     = sdpg_pkg::AXES_DEFAULT;
   localparam int     SHOW_LIMIT = 10;
   localparam int     TAIL_CYCLES = 6;
   localparam longint S32_MAX    = 2147483647;
   localparam longint S32_MIN    = -S32_MAX - 1;

   typedef struct packed {
      logic [2:0]  func;
      logic [2:0]  axis;
      logic [31:0] move_steps;
      logic [31:0] target_position;
      logic [31:0] new_position;
      logic [23:0] period_whole;
      logic [6:0]  period_hundredths;
   } step_cmd_type;

   typedef struct packed {
      logic        step;
      logic        dir;
      logic [31:0] steps_left;
      logic [31:0] position;
      logic        busy;
   } axis_status_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   sdpg_req_if req_bus ();
   sdpg_rsp_if rsp_bus ();

   step_dir_pulse_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // axis model
   logic [7:0]  dir_mask;
   logic        pulse_lvl  [N_AXES];
   logic        dir_lvl    [N_AXES];
   logic [31:0] steps_todo [N_AXES];
   logic [31:0] pos_cnt    [N_AXES];
   logic [23:0] per_whole  [N_AXES];
   logic [6:0]  per_frac   [N_AXES];
   logic [23:0] div_cnt    [N_AXES];
   logic [6:0]  hund_cnt   [N_AXES];

   axis_status_type status_q[$];
   int mismatches;
   int items_sent;
   bit src_idle_on;
   bit snk_idle_on;
   int hold_req;
   int stall_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void reset_axes();
      dir_mask = 8'h00;
      for (int a = 0; a < N_AXES; a++) begin
         pulse_lvl[a]  = 1'b0;
         dir_lvl[a]    = 1'b0;
         steps_todo[a] = '0;
         pos_cnt[a]    = '0;
         per_whole[a]  = 24'(sdpg_pkg::PERIOD_RESET);
         per_frac[a]   = '0;
         div_cnt[a]    = '0;
         hund_cnt[a]   = '0;
      end
   endfunction

   function automatic void start_travel(input int a, input logic [31:0] steps);
      if (steps == 32'd0) begin
         steps_todo[a] = '0;
         return;
      end
      dir_lvl[a]    = ~steps[31] ^ dir_mask[a];
      steps_todo[a] = steps;
   endfunction

   function automatic void tick_axis(input int a);
      pulse_lvl[a] = 1'b0;
      if (steps_todo[a] == 32'd0) return;
      div_cnt[a] = div_cnt[a] + 24'd1;
      if (div_cnt[a] < per_whole[a]) return;
      div_cnt[a]  = (hund_cnt[a] > per_frac[a]) ? 24'd1 : 24'd0;
      hund_cnt[a] = hund_cnt[a] + 7'd1;
      if (hund_cnt[a] >= sdpg_pkg::FRAC_WRAP) hund_cnt[a] = '0;
      pulse_lvl[a] = 1'b1;
      if (steps_todo[a][31]) begin
         steps_todo[a] = steps_todo[a] + 32'd1;
         pos_cnt[a]    = pos_cnt[a] - 32'd1;
      end else begin
         steps_todo[a] = steps_todo[a] - 32'd1;
         pos_cnt[a]    = pos_cnt[a] + 32'd1;
      end
   endfunction

   function automatic axis_status_type next_axis_status(input step_cmd_type c);
      int              a;
      longint          delta;
      axis_status_type s;
      a = int'(c.axis);
      case (c.func)
         sdpg_pkg::FUNC_TICK: tick_axis(a);
         sdpg_pkg::FUNC_MOVE: start_travel(a, c.move_steps);
         sdpg_pkg::FUNC_GOTO: begin
            delta = longint'($signed(c.target_position)) - longint'($signed(pos_cnt[a]));
            if (delta > S32_MAX) delta = S32_MAX;
            if (delta < S32_MIN) delta = S32_MIN;
            start_travel(a, delta[31:0]);
         end
         sdpg_pkg::FUNC_SET_POS: pos_cnt[a] = c.new_position;
         sdpg_pkg::FUNC_SET_PERIOD: begin
            per_whole[a] = c.period_whole;
            per_frac[a]  = c.period_hundredths;
         end
         default: ;
      endcase
      s.step       = pulse_lvl[a];
      s.dir        = dir_lvl[a];
      s.steps_left = steps_todo[a];
      s.position   = pos_cnt[a];
      s.busy       = (steps_todo[a] != 32'd0);
      return s;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic step_cmd_type rand_cmd(input logic [2:0] fn, input logic [2:0] ax);
      step_cmd_type c;
      c.func              = fn;
      c.axis              = ax;
      c.move_steps        = $urandom;
      c.target_position   = $urandom;
      c.new_position      = $urandom;
      c.period_whole      = 24'($urandom_range(0, 24'hFF_FFFF));
      c.period_hundredths = 7'($urandom_range(0, 127));
      return c;
   endfunction

   task automatic send_item(input step_cmd_type c);
      int gap;
      gap = 0;
      if (src_idle_on && $urandom_range(0, 99) >= 55) gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.func              <= c.func;
      req_bus.axis              <= c.axis;
      req_bus.move_steps        <= c.move_steps;
      req_bus.target_position   <= c.target_position;
      req_bus.new_position      <= c.new_position;
      req_bus.period_whole      <= c.period_whole;
      req_bus.period_hundredths <= c.period_hundredths;
      req_bus.valid             <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      status_q.push_back(next_axis_status(c));
      items_sent++;
   endtask

   task automatic issue(input logic [2:0] fn, input logic [2:0] ax, input logic [31:0] arg,
                        input logic [6:0] hund);
      step_cmd_type c;
      c = rand_cmd(fn, ax);
      case (fn)
         sdpg_pkg::FUNC_MOVE:    c.move_steps      = arg;
         sdpg_pkg::FUNC_GOTO:    c.target_position = arg;
         sdpg_pkg::FUNC_SET_POS: c.new_position    = arg;
         sdpg_pkg::FUNC_SET_PERIOD: begin
            c.period_whole      = arg[23:0];
            c.period_hundredths = hund;
         end
         default: ;
      endcase
      send_item(c);
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_dir_mask(input logic [7:0] v);
      wait_results_done();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      dir_mask = v;
   endtask

   // transfer on rsp_bus: compare against oldest expectation
   always @(posedge clock) begin : check_results
      axis_status_type got;
      axis_status_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.step       = rsp_bus.step_level;
         got.dir        = rsp_bus.dir_level;
         got.steps_left = rsp_bus.steps_left;
         got.position   = rsp_bus.position;
         got.busy       = rsp_bus.busy_res;
         if (status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("unexpected result transfer at %0t", $realtime);
         end else begin
            want = status_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT) begin
                  $display("mismatch at %0t (exp/act): step %b/%b dir %b/%b busy %b/%b",
                           $realtime, want.step, got.step, want.dir, got.dir,
                           want.busy, got.busy);
                  $display("   left %0d/%0d pos %0d/%0d",
                           $signed(want.steps_left), $signed(got.steps_left),
                           $signed(want.position), $signed(got.position));
               end
            end
         end
      end
   end

   // receiver pacing, with an optional long hold-off
   always @(negedge clock) begin : rsp_pacing
      if (hold_req > 0) begin
         stall_left = hold_req;
         hold_req   = 0;
      end
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = gap_len() - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic test_idle_axis();
      issue(sdpg_pkg::FUNC_TICK, 3'd0, 32'd0, 7'd0);
      issue(FUNC_RSVD_5, 3'd1, 32'hFFFF_FFFF, 7'd0);
      issue(FUNC_RSVD_6, 3'd2, 32'h0000_0000, 7'd0);
      issue(FUNC_RSVD_7, 3'd7, 32'h8000_0000, 7'd0);
   endtask

   task automatic test_moves();
      issue(sdpg_pkg::FUNC_MOVE, 3'd1, 32'd3, 7'd0);
      issue(sdpg_pkg::FUNC_MOVE, 3'd2, -32'sd2, 7'd0);
      issue(sdpg_pkg::FUNC_MOVE, 3'd1, 32'd0, 7'd0);
      issue(sdpg_pkg::FUNC_MOVE, 3'd3, 32'h7FFF_FFFF, 7'd0);
      issue(sdpg_pkg::FUNC_MOVE, 3'd4, 32'h8000_0000, 7'd0);
   endtask

   task automatic test_fast_period();
      issue(sdpg_pkg::FUNC_SET_PERIOD, 3'd5, 32'd0, 7'd0);
      issue(sdpg_pkg::FUNC_MOVE, 3'd5, 32'd2, 7'd0);
      repeat (2) issue(sdpg_pkg::FUNC_TICK, 3'd5, 32'd0, 7'd0);
      // hundredths above 99 never shorten a period
      issue(sdpg_pkg::FUNC_SET_PERIOD, 3'd5, 32'h00FF_FFFF, 7'd127);
   endtask

   task automatic test_period_lowered();
      issue(sdpg_pkg::FUNC_MOVE, 3'd6, 32'd1, 7'd0);
      repeat (2) issue(sdpg_pkg::FUNC_TICK, 3'd6, 32'd0, 7'd0);
      issue(sdpg_pkg::FUNC_SET_PERIOD, 3'd6, 32'd1, 7'd99);
      issue(sdpg_pkg::FUNC_TICK, 3'd6, 32'd0, 7'd0);
   endtask

   task automatic test_position_limits();
      issue(sdpg_pkg::FUNC_SET_POS, 3'd7, 32'h7FFF_FFFF, 7'd0);
      issue(sdpg_pkg::FUNC_SET_PERIOD, 3'd7, 32'd0, 7'd0);
      issue(sdpg_pkg::FUNC_MOVE, 3'd7, 32'd1, 7'd0);
      issue(sdpg_pkg::FUNC_TICK, 3'd7, 32'd0, 7'd0);
      issue(sdpg_pkg::FUNC_GOTO, 3'd7, 32'h7FFF_FFFF, 7'd0);
      issue(sdpg_pkg::FUNC_SET_POS, 3'd7, 32'h7FFF_FFFF, 7'd0);
      issue(sdpg_pkg::FUNC_GOTO, 3'd7, 32'h8000_0000, 7'd0);
   endtask

   task automatic axis_burst(input logic [2:0] ax);
      int          d;
      int          n;
      logic [31:0] extreme;
      if ($urandom_range(0, 7) == 0)
         issue(sdpg_pkg::FUNC_SET_PERIOD, ax, $urandom_range(4, 30),
               7'($urandom_range(0, 127)));
      else
         issue(sdpg_pkg::FUNC_SET_PERIOD, ax, $urandom_range(0, 3),
               7'($urandom_range(0, 127)));
      if ($urandom_range(0, 9) == 0) begin
         extreme = $urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_000F;
         issue(sdpg_pkg::FUNC_SET_POS, ax, extreme + $urandom_range(0, 15) - 32'd8, 7'd0);
      end
      d = $urandom_range(1, 8);
      if ($urandom_range(0, 1)) d = -d;
      case ($urandom_range(0, 9))
         0:       issue(sdpg_pkg::FUNC_MOVE, ax, $urandom, 7'd0);
         1, 2, 3: issue(sdpg_pkg::FUNC_GOTO, ax, pos_cnt[ax] + d, 7'd0);
         default: issue(sdpg_pkg::FUNC_MOVE, ax, d, 7'd0);
      endcase
      n = $urandom_range(2, 40);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0)
            send_item(rand_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, N_AXES - 1))));
         else
            issue(sdpg_pkg::FUNC_TICK, ax, 32'd0, 7'd0);
      end
   endtask

   task automatic run_bursts(input int n);
      int stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8)
            axis_burst(3'($urandom_range(0, N_AXES - 1)));
         else
            send_item(rand_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, N_AXES - 1))));
      end
   endtask

   task automatic test_direction_mask();
      write_dir_mask(8'hFF);
      run_bursts(250);
      write_dir_mask(8'hA5);
      run_bursts(250);
   endtask

   // long run on one axis so the hundredths counter wraps
   task automatic test_fractional();
      logic [2:0] ax;
      ax = 3'($urandom_range(0, N_AXES - 1));
      src_idle_on = 1'b0;
      snk_idle_on = 1'b0;
      issue(sdpg_pkg::FUNC_SET_PERIOD, ax, 32'd2, 7'($urandom_range(0, 99)));
      issue(sdpg_pkg::FUNC_MOVE, ax, 32'd150, 7'd0);
      repeat (400) issue(sdpg_pkg::FUNC_TICK, ax, 32'd0, 7'd0);
      src_idle_on = 1'b1;
      snk_idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      src_idle_on = 1'b0;
      hold_req    = 200;
      repeat (40) issue(sdpg_pkg::FUNC_TICK, 3'($urandom_range(0, N_AXES - 1)), 32'd0, 7'd0);
      src_idle_on = 1'b1;
   endtask

   task automatic test_random_masks();
      repeat (3) begin
         write_dir_mask(8'($urandom_range(0, 255)));
         run_bursts(200);
      end
      write_dir_mask(8'h00);
      run_bursts(100);
   endtask

   initial begin
      reset                     = 1'b1;
      csr_wr_en                 = 1'b0;
      csr_wr_data               = 8'h00;
      req_bus.valid             = 1'b0;
      req_bus.func              = sdpg_pkg::FUNC_TICK;
      req_bus.axis              = '0;
      req_bus.move_steps        = '0;
      req_bus.target_position   = '0;
      req_bus.new_position      = '0;
      req_bus.period_whole      = '0;
      req_bus.period_hundredths = '0;
      rsp_bus.ready             = 1'b0;
      mismatches  = 0;
      items_sent  = 0;
      hold_req    = 0;
      stall_left  = 0;
      src_idle_on = 1'b1;
      snk_idle_on = 1'b1;
      reset_axes();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_dir_mask(8'h00);
      test_idle_axis();
      test_moves();
      test_fast_period();
      test_period_lowered();
      test_position_limits();
      test_direction_mask();
      test_fractional();
      test_backpressure();
      test_random_masks();

      wait_results_done();
      if (mismatches == 0 && status_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
